@@ rtl/core/mbe_pkg.sv @@
`timescale 1ns / 1ps

package mbe_pkg;

  // Fraction bits of the point coordinates.
  localparam int unsigned MBE_FRAC_BITS   = 28;
  // Coordinate width on the input channel.
  localparam int unsigned MBE_COORD_W     = 32;
  // Width of the iteration count and of the limit register.
  localparam int unsigned MBE_COUNT_W     = 8;
  // Limb width of the shared multiplier.
  localparam int unsigned MBE_LIMB_W      = 32;
  // Limit register value after reset.
  localparam logic [MBE_COUNT_W-1:0] MBE_LIMIT_RESET = 8'd255;

  // Handshake between the sequencer and the shared multiplier.
  typedef struct packed {
    logic start;
  } mbe_mul_req_t;

  typedef struct packed {
    logic done;
  } mbe_mul_rsp_t;

endpackage

@@ rtl/core/mbe_if.sv @@
`timescale 1ns / 1ps

// Point channel: one complex point c per item.
interface mbe_point_if
  import mbe_pkg::*;
  ();
  logic                          valid;
  logic                          ready;
  logic signed [MBE_COORD_W-1:0] c_real;
  logic signed [MBE_COORD_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// Result channel: escape count and flag per item.
interface mbe_result_if
  import mbe_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [MBE_COUNT_W-1:0] iteration_count;
  logic                   escaped;

  modport source (output valid, output iteration_count, output escaped, input ready);
  modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

// Configuration write channel: iteration limit.
interface mbe_cfg_if
  import mbe_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [MBE_COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/mandelbrot_escape_iteration_core.sv @@
`timescale 1ns / 1ps

// Mandelbrot escape-time core. Each item on point_i is a complex point c in
// signed fixed point (FRAC_BITS fraction bits); the core iterates z = z*z + c
// from z = 0 and returns on result_o the number of update passes done and
// whether |z|^2 went above 4. A pass runs only while |z|^2 <= 4 and the count
// is below the limit in cfg_i (0 acts as 1). All three products of a pass
// (x*x, y*y, x*y) run on one shared multiplier that takes one 32x32 limb pair
// per cycle; with L = ceil((max(FRAC_BITS,29)+4)/32) limbs a product is built
// from L*L limb pairs. An item runs one more set of products than its count,
// since the first bound test also waits on a full set of products.
// The core takes one point at a time; a finished result sits in an output
// register, so the next point can be taken while it waits.
module mandelbrot_escape_iteration_core
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = MBE_FRAC_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mbe_point_if.sink    point_i,
  mbe_result_if.source result_o,
  mbe_cfg_if.sink      cfg_i
);

  // Coordinate width that holds z for any point without overflow.
  localparam int unsigned W = ((FRAC_BITS > 29) ? FRAC_BITS : 29) + 4;
  localparam int unsigned P = 2 * W;
  localparam logic [P:0]  FOUR = (P+1)'(1) << (2 * FRAC_BITS + 2);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MXX  = 3'd1;
  localparam logic [2:0] S_MYY  = 3'd2;
  localparam logic [2:0] S_MXY  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic                          start_q, start_d;
  logic signed [W-1:0]           x_q, x_d, y_q, y_d;
  logic signed [MBE_COORD_W-1:0] cr_q, cr_d, ci_q, ci_d;
  logic [MBE_COUNT_W-1:0]        count_q, count_d;
  logic [P-1:0]                  xx_q, xx_d, yy_q, yy_d, xy_q, xy_d;
  logic [MBE_COUNT_W-1:0]        limit_q;
  logic                          res_valid_q, res_valid_d;
  logic [MBE_COUNT_W-1:0]        res_count_q, res_count_d;
  logic                          res_esc_q, res_esc_d;

  logic                   pt_acc, out_free;
  logic [W-1:0]           ax, ay, mul_a, mul_b;
  logic [P-1:0]           mul_prod;
  mbe_mul_req_t           mul_req;
  mbe_mul_rsp_t           mul_rsp;
  logic [P:0]             mag2;
  logic                   esc;
  logic [MBE_COUNT_W-1:0] lim;
  logic                   stop;
  logic signed [P:0]      diff, diff_sh;
  logic signed [P+1:0]    xy_s, txy, txy_sh;
  logic [W-1:0]           x_new, y_new;

  assign pt_acc   = point_i.valid && point_i.ready;
  assign out_free = !res_valid_q || result_o.ready;

  assign point_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;

  // Magnitudes go to the unsigned multiplier; signs are applied afterwards.
  assign ax = x_q[W-1] ? W'(-x_q) : W'(x_q);
  assign ay = y_q[W-1] ? W'(-y_q) : W'(y_q);

  always_comb begin
    unique case (state_q)
      S_MYY: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_MXY: begin
        mul_a = ax;
        mul_b = ay;
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  assign mul_req.start = start_q;

  mbe_mul #(
    .WIDTH (W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rsp_o  (mul_rsp),
    .prod_o (mul_prod)
  );

  // Bound test on the exact squares.
  assign mag2 = {1'b0, xx_q} + {1'b0, yy_q};
  assign esc  = mag2 > FOUR;
  assign lim  = (limit_q == '0) ? MBE_COUNT_W'(1) : limit_q;
  assign stop = esc || (count_q >= lim);

  // Update: floor((xx - yy) / 2^F) + cr and floor(2xy / 2^F) + ci.
  assign diff    = $signed({1'b0, xx_q}) - $signed({1'b0, yy_q});
  assign diff_sh = diff >>> FRAC_BITS;
  assign xy_s    = $signed({2'b00, xy_q});
  assign txy     = ((x_q[W-1] ^ y_q[W-1]) ? -xy_s : xy_s) <<< 1;
  assign txy_sh  = txy >>> FRAC_BITS;
  assign x_new   = diff_sh[W-1:0] + W'(cr_q);
  assign y_new   = txy_sh[W-1:0] + W'(ci_q);

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    x_d         = x_q;
    y_d         = y_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    count_d     = count_q;
    xx_d        = xx_q;
    yy_d        = yy_q;
    xy_d        = xy_q;
    res_valid_d = res_valid_q && !result_o.ready;
    res_count_d = res_count_q;
    res_esc_d   = res_esc_q;
    unique case (state_q)
      S_IDLE: begin
        if (pt_acc) begin
          x_d     = '0;
          y_d     = '0;
          cr_d    = point_i.c_real;
          ci_d    = point_i.c_imag;
          count_d = '0;
          state_d = S_MXX;
          start_d = 1'b1;
        end
      end
      S_MXX: begin
        if (mul_rsp.done) begin
          xx_d    = mul_prod;
          state_d = S_MYY;
          start_d = 1'b1;
        end
      end
      S_MYY: begin
        if (mul_rsp.done) begin
          yy_d    = mul_prod;
          state_d = S_MXY;
          start_d = 1'b1;
        end
      end
      S_MXY: begin
        if (mul_rsp.done) begin
          xy_d    = mul_prod;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stop) begin
          // hold here until the output register is free
          if (out_free) begin
            res_valid_d = 1'b1;
            res_count_d = count_q;
            res_esc_d   = esc;
            state_d     = S_IDLE;
          end
        end else begin
          x_d     = x_new;
          y_d     = y_new;
          count_d = count_q + 1'b1;
          state_d = S_MXX;
          start_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      res_valid_q <= 1'b0;
      limit_q     <= MBE_LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    cr_q        <= cr_d;
    ci_q        <= ci_d;
    count_q     <= count_d;
    xx_q        <= xx_d;
    yy_q        <= yy_d;
    xy_q        <= xy_d;
    res_count_q <= res_count_d;
    res_esc_q   <= res_esc_d;
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.iteration_count = res_count_q;
  assign result_o.escaped         = res_esc_q;

  // An accepted point starts the first square right away.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_acc |=> (state_q == S_MXX) && start_q)
    else $error("accepted point did not start the multiplier");

  // The multiplier only finishes while the sequencer waits on it.
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == S_MXX) || (state_q == S_MYY) || (state_q == S_MXY))
    else $error("multiplier done outside a product state");

  // At least one pass always runs before a result is posted.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> (res_count_q != '0))
    else $error("result posted with zero passes");

  // A start never lands while a result is being posted.
  a_no_start_on_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) && stop |=> !start_q)
    else $error("multiplier restarted at end of item");

endmodule

@@ rtl/core/mbe_mul.sv @@
`timescale 1ns / 1ps

// Unsigned WIDTH x WIDTH multiplier built from one 32x32 multiplier,
// one limb pair per cycle. Operands must stay stable from start until done.
module mbe_mul
  import mbe_pkg::*;
#(
  parameter int unsigned WIDTH = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbe_mul_req_t       req_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output mbe_mul_rsp_t       rsp_o,
  output logic [2*WIDTH-1:0] prod_o
);

  localparam int unsigned L  = (WIDTH + MBE_LIMB_W - 1) / MBE_LIMB_W;
  localparam int unsigned PW = L * MBE_LIMB_W;
  localparam int unsigned AW = 2 * PW;
  localparam int unsigned IW = (L > 1) ? $clog2(L) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(L - 1);

  logic [PW-1:0]           a_pad, b_pad;
  logic [MBE_LIMB_W-1:0]   a_limb, b_limb;
  logic [IW-1:0]           i_q, i_d, j_q, j_d;
  logic                    issue_q, issue_d;
  logic                    last_pair;
  logic [2*MBE_LIMB_W-1:0] pp_q;
  logic [IW:0]             sh_q;
  logic                    pvalid_q, plast_q, done_q;
  logic [AW-1:0]           acc_q;

  assign a_pad     = PW'(a_i);
  assign b_pad     = PW'(b_i);
  assign a_limb    = a_pad[i_q*MBE_LIMB_W +: MBE_LIMB_W];
  assign b_limb    = b_pad[j_q*MBE_LIMB_W +: MBE_LIMB_W];
  assign last_pair = (i_q == LAST_IDX) && (j_q == LAST_IDX);

  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    issue_d = issue_q;
    if (req_i.start) begin
      i_d     = '0;
      j_d     = '0;
      issue_d = 1'b1;
    end else if (issue_q) begin
      if (last_pair) begin
        issue_d = 1'b0;
      end else if (j_q == LAST_IDX) begin
        j_d = '0;
        i_d = i_q + 1'b1;
      end else begin
        j_d = j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q      <= '0;
      j_q      <= '0;
      issue_q  <= 1'b0;
      pvalid_q <= 1'b0;
      plast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      i_q      <= i_d;
      j_q      <= j_d;
      issue_q  <= issue_d;
      pvalid_q <= issue_q && !req_i.start;
      plast_q  <= issue_q && last_pair;
      done_q   <= pvalid_q && plast_q && !req_i.start;
    end
  end

  // Partial product register, then shifted accumulate.
  always_ff @(posedge clk_i) begin
    pp_q <= a_limb * b_limb;
    sh_q <= {1'b0, i_q} + {1'b0, j_q};
    if (req_i.start) begin
      acc_q <= '0;
    end else if (pvalid_q) begin
      acc_q <= acc_q + (AW'(pp_q) << (MBE_LIMB_W * sh_q));
    end
  end

  assign rsp_o.done = done_q;
  assign prod_o     = acc_q[2*WIDTH-1:0];

endmodule
